FILE: rtl/ntr_pkg.sv
// ============================================================================
// ntr_pkg: shared types and constants for the narrow tongue remover
// Cell type codes, line buffer entry layout and the tongue tip rule.
// ============================================================================
`default_nettype none

package ntr_pkg;

    // Field widths
    localparam int TYPE_W   = 2;
    localparam int THICK_W  = 24;
    localparam int CFG_W    = 11;
    localparam int PW_RESET = 1024;

    typedef logic [TYPE_W-1:0] t_cell;

    // Cell type codes
    localparam t_cell CT_GROUND   = 2'd0;
    localparam t_cell CT_GROUNDED = 2'd1;
    localparam t_cell CT_FLOATING = 2'd2;
    localparam t_cell CT_OCEAN    = 2'd3;

    // One window column, top row first
    typedef struct packed {
        t_cell top;
        t_cell mid;
        t_cell bot;
    } t_col;

    // One line buffer entry: the two stored type rows and the thickness row
    typedef struct packed {
        t_cell               above;
        t_cell               mid;
        logic [THICK_W-1:0]  thick;
    } t_line;

    // A grounded centre sees only open ocean as free
    function automatic logic is_free(input t_cell t, input logic grounded);
        logic res;
        if (grounded) begin
            res = (t == CT_OCEAN);
        end else begin
            res = (t == CT_OCEAN) || (t == CT_GROUND);
        end
        return res;
    endfunction

    // Icy centre with one non-free side whose two corners are free, all other sides free
    function automatic logic tongue_tip(input t_col lf, input t_col cn, input t_col rt);
        logic g;
        logic n, s, w, e, nw, ne, sw, se;
        logic icy;
        icy = (cn.mid == CT_GROUNDED) || (cn.mid == CT_FLOATING);
        g   = (cn.mid == CT_GROUNDED);
        n   = is_free(cn.top, g);
        s   = is_free(cn.bot, g);
        w   = is_free(lf.mid, g);
        e   = is_free(rt.mid, g);
        nw  = is_free(lf.top, g);
        ne  = is_free(rt.top, g);
        sw  = is_free(lf.bot, g);
        se  = is_free(rt.bot, g);
        return icy && ((!w && nw && sw && n && s && e) ||
                       (!n && nw && ne && w && e && s) ||
                       (!e && ne && se && w && s && n) ||
                       (!s && sw && se && w && e && n));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/narrow_tongue_remover.sv
// A result passes through the stage 1 registers and then the output register.
// Throughput: one cell per cycle unless the output stalls; the line buffer memory
// is read on input transfer and written back when stage 1 advances, with a forward
// path for back-to-back hits. Each interior cell yields one result, delayed by one
// row and one column. Reset (synchronous, active low) clears counters, window and
// valid flags; the line buffer has no reset and is read before its first write.
// ============================================================================
// narrow_tongue_remover: 3x3 window narrow ice tongue removal
// Raster cells feed a line buffer memory and a 3x3 type window; an icy
// centre whose only non-free side neighbour has free corners beside it is zeroed.
// ============================================================================
`default_nettype none

module narrow_tongue_remover #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ntr_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [ntr_pkg::TYPE_W-1:0]   i_cell_type,
    input  logic [ntr_pkg::THICK_W-1:0]  i_thickness_in,
    input  logic                         i_frame_start,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ntr_pkg::THICK_W-1:0]  o_thickness_out,
    output logic                         o_removed,
    output logic                         o_row_end
);
    import ntr_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CFG_W > CW) ? CFG_W : CW;
    localparam logic [EW-1:0] MAXL = EW'(MAX_WIDTH - 1);
    localparam logic [CW-1:0] LAST_RST =
        CW'((MAX_WIDTH < PW_RESET) ? MAX_WIDTH - 1 : PW_RESET - 1);

    // Configuration: last column index, clamped at write time
    logic [CW-1:0] r_last;
    logic [CW-1:0] cfg_last;
    logic [EW-1:0] cfg_e;

    always_comb begin
        cfg_e = EW'(i_cfg_wdata);
        if (cfg_e < EW'(3)) begin
            cfg_last = CW'(2);
        end else if (cfg_e - EW'(1) > MAXL) begin
            cfg_last = MAXL[CW-1:0];
        end else begin
            cfg_last = CW'(cfg_e - EW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= LAST_RST;
        end else if (i_cfg_we) begin
            r_last <= cfg_last;
        end
    end

    // Handshake
    logic r_s1_v;
    logic r_ov;
    logic s1_adv;
    logic accept;

    assign s1_adv     = r_s1_v && (!r_ov || !i_out_stall);
    assign o_in_stall = r_s1_v && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    // Stage 0: position of the arriving cell
    logic [CW-1:0] r_col;
    logic [1:0]    r_row_lvl;
    logic [CW-1:0] col0;
    logic [CW-1:0] c0;
    logic [1:0]    row0;
    logic          last0;

    always_comb begin
        col0  = i_frame_start ? '0 : r_col;
        c0    = (col0 > r_last) ? r_last : col0;
        row0  = i_frame_start ? 2'd0 : r_row_lvl;
        last0 = (c0 == r_last);
    end

    // Advance column and row; row level saturates once two rows are in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row_lvl <= 2'd0;
        end else if (accept) begin
            if (last0) begin
                r_col     <= '0;
                r_row_lvl <= (row0 == 2'd2) ? 2'd2 : row0 + 2'd1;
            end else begin
                r_col     <= c0 + CW'(1);
                r_row_lvl <= row0;
            end
        end
    end

    // Stage 1 registers
    logic [CW-1:0]      r_s1_c;
    t_cell              r_s1_type;
    logic [THICK_W-1:0] r_s1_th;
    logic               r_s1_emit;
    logic               r_s1_rowend;
    logic               r_fwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
                r_fwd  <= s1_adv && (c0 == r_s1_c);
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
                r_fwd  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_c      <= c0;
            r_s1_type   <= i_cell_type;
            r_s1_th     <= i_thickness_in;
            r_s1_emit   <= (row0 == 2'd2) && (c0 >= CW'(2));
            r_s1_rowend <= last0;
        end
    end

    // Line buffer memory: read on transfer, write back when stage 1 advances
    t_line mem [MAX_WIDTH];
    t_line r_rd;
    t_line r_fw;
    t_line rd_eff;
    t_line wr_entry;

    assign rd_eff   = r_fwd ? r_fw : r_rd;
    assign wr_entry = '{above: rd_eff.mid, mid: r_s1_type, thick: r_s1_th};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[c0];
        end
        if (s1_adv) begin
            mem[r_s1_c] <= wr_entry;
        end
    end

    // Hold the written entry for a read of the same address in that cycle
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_fw <= wr_entry;
        end
    end

    // Window: two stored columns plus the incoming one
    t_col               r_wc1;
    t_col               r_wc2;
    t_col               new_col;
    logic [THICK_W-1:0] r_wt1;
    logic               tip;

    assign new_col = '{top: rd_eff.above, mid: rd_eff.mid, bot: r_s1_type};
    assign tip     = tongue_tip(r_wc1, r_wc2, new_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc1 <= '0;
            r_wc2 <= '0;
            r_wt1 <= '0;
        end else if (s1_adv) begin
            r_wc1 <= r_wc2;
            r_wc2 <= new_col;
            r_wt1 <= rd_eff.thick;
        end
    end

    // Output register
    logic [THICK_W-1:0] r_out_th;
    logic               r_out_rm;
    logic               r_out_re;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s1_adv) begin
            r_ov <= r_s1_emit;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_th <= tip ? '0 : r_wt1;
            r_out_rm <= tip;
            r_out_re <= r_s1_rowend;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_thickness_out = r_out_th;
    assign o_removed       = r_out_rm;
    assign o_row_end       = r_out_re;

endmodule

`default_nettype wire

FILE: rtl/ntr_checker.sv
// ============================================================================
// ntr_checker: port level checks for the narrow tongue remover
// Watches the handshake and result fields over time.
// ============================================================================
`default_nettype none

module ntr_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic [ntr_pkg::THICK_W-1:0]  o_thickness_out,
    input  logic                         o_removed,
    input  logic                         o_row_end
);
    import ntr_pkg::*;

    // A stalled result holds its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_thickness_out)
            && $stable(o_removed) && $stable(o_row_end))
        else $error("result changed while stalled");

    // A removed cell always reports zero thickness
    a_rm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_removed |-> o_thickness_out == '0)
        else $error("removed cell with nonzero thickness");

    // Input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // A fresh result follows an input transfer through stage 1 and the output register
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without matching input transfer");

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind narrow_tongue_remover ntr_checker u_ntr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_thickness_out (o_thickness_out),
    .o_removed       (o_removed),
    .o_row_end       (o_row_end)
);

`default_nettype wire

FILE: bench/narrow_tongue_remover_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// narrow_tongue_remover_tb: self-checking bench for the tongue remover
// Streams grids of random and hand-built cells through the block,
// keeps its own line buffers and 3x3 window to predict every interior
// result, and compares each output transfer in order against the oldest
// prediction. Both sides idle at random; widths cover the clamped ends.
// ============================================================================

module narrow_tongue_remover_tb;
    import ntr_pkg::*;

    localparam int LB_DEPTH      = 1024;
    localparam int IDLE_PCT      = 22;
    localparam int WATCH_MAX     = 2000;
    localparam int SETTLE_CYC    = 8;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_CELLS  = 240;
    localparam int PARTIAL_CELLS = 32;
    localparam int CALM_ROWS     = 20;
    localparam logic [THICK_W-1:0] THICK_MAX = '1;

    // One interior result as the block reports it
    typedef struct packed {
        logic [THICK_W-1:0] thick;
        logic               removed;
        logic               row_end;
    } t_centre;

    // Block ports
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata   = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    t_cell              cell_type   = CT_GROUND;
    logic [THICK_W-1:0] thick_in    = '0;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [THICK_W-1:0] thick_out;
    logic               removed;
    logic               row_end;

    // Bench control and tallies
    logic        calm         = 1'b0;
    int          quiet_cycles = 0;
    int          failures     = 0;
    int unsigned cells_sent   = 0;
    int unsigned frames_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned tips_seen    = 0;

    // Predictor state: line buffers, window, counters, width register
    t_cell              lb_above  [LB_DEPTH];
    t_cell              lb_mid    [LB_DEPTH];
    logic [THICK_W-1:0] lb_thick  [LB_DEPTH];
    t_cell              win       [3][3];
    logic [THICK_W-1:0] win_thick [2];
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    logic [CFG_W-1:0]   width_reg;
    t_centre            centre_q [$];

    narrow_tongue_remover #(
        .MAX_WIDTH(LB_DEPTH)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cell_type    (cell_type),
        .i_thickness_in (thick_in),
        .i_frame_start  (frame_start),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_thickness_out(thick_out),
        .o_removed      (removed),
        .o_row_end      (row_end)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp the written width to what the block can hold
    function automatic int unsigned eff_width(logic [CFG_W-1:0] v);
        if (v < 3) begin
            return 3;
        end
        if (v > LB_DEPTH) begin
            return LB_DEPTH;
        end
        return v;
    endfunction

    // Grounded ice sees only ocean as open; floating ice also bare ground
    function automatic logic open_for(t_cell t, logic grounded);
        return (t == CT_OCEAN) || (!grounded && t == CT_GROUND);
    endfunction

    // Walk the eight neighbours clockwise from north; each side sits at an
    // even slot with its two near corners on either side of it
    function automatic logic tip_found();
        t_cell ring [8];
        logic  clear_at [8];
        logic  grounded;
        logic  hit;
        if (win[1][1] != CT_GROUNDED && win[1][1] != CT_FLOATING) begin
            return 1'b0;
        end
        ring = '{win[0][1], win[0][2], win[1][2], win[2][2],
                 win[2][1], win[2][0], win[1][0], win[0][0]};
        grounded = (win[1][1] == CT_GROUNDED);
        for (int k = 0; k < 8; k++) begin
            clear_at[k] = open_for(ring[k], grounded);
        end
        hit = 1'b0;
        for (int s = 0; s < 8; s += 2) begin
            if (!clear_at[s] && clear_at[(s + 7) % 8] && clear_at[s + 1] &&
                clear_at[(s + 2) % 8] && clear_at[(s + 4) % 8] && clear_at[(s + 6) % 8]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Advance the predictor by one transferred cell
    function automatic void model_cell(t_cell t, logic [THICK_W-1:0] th, logic start);
        int unsigned        pw;
        int unsigned        c;
        int unsigned        r;
        t_cell              above;
        t_cell              mid;
        logic [THICK_W-1:0] thick_mid;
        t_centre            res;
        pw = eff_width(width_reg);
        if (start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c = (col_cnt >= pw) ? pw - 1 : col_cnt;
        r = row_cnt;

        // Read the column, then push the rows down one line
        above     = lb_above[c];
        mid       = lb_mid[c];
        thick_mid = lb_thick[c];
        lb_above[c] = mid;
        lb_mid[c]   = t;
        lb_thick[c] = th;

        // Shift the window left and load the new column
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]    = above;
        win[1][2]    = mid;
        win[2][2]    = t;
        win_thick[0] = win_thick[1];
        win_thick[1] = thick_mid;

        if (r >= 2 && c >= 2) begin
            res.removed = tip_found();
            res.thick   = res.removed ? '0 : win_thick[0];
            res.row_end = (c == pw - 1);
            centre_q.push_back(res);
        end

        if (c + 1 >= pw) begin
            col_cnt = 0;
            if (row_cnt < 16'hFFFF) begin
                row_cnt++;
            end
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    // Offer one cell, hold it until it transfers, then predict
    task automatic send_cell(t_cell t, logic [THICK_W-1:0] th, logic start);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid    <= 1'b1;
        cell_type   <= t;
        thick_in    <= th;
        frame_start <= start;
        do @(posedge clk); while (in_stall);
        model_cell(t, th, start);
        cells_sent++;
    endtask

    // Stop offering, wait for every prediction to be met, let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (centre_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write the width register only while the block is idle
    task automatic set_width(logic [CFG_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        width_reg = v;
        cfg_we    <= 1'b0;
    endtask

    // Send a run of random cells; ocean_pct biases toward open water
    task automatic send_cells(int unsigned count, int ocean_pct, logic start,
                              logic restarts);
        logic               fs;
        t_cell              t;
        logic [THICK_W-1:0] th;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < ocean_pct) begin
                t = CT_OCEAN;
            end else begin
                case ($urandom_range(2))
                    0: t = CT_GROUND;
                    1: t = CT_GROUNDED;
                    default: t = CT_FLOATING;
                endcase
            end
            if ($urandom_range(99) < 10) begin
                th = $urandom_range(1) ? THICK_MAX : '0;
            end else begin
                th = THICK_W'($urandom);
            end
            fs = (i == 0) ? start : (restarts && $urandom_range(99) == 0);
            send_cell(t, th, fs);
        end
    endtask

    // Send a whole grid of random cells at the current width
    task automatic send_frame(int rows, int ocean_pct, logic start, logic restarts);
        int unsigned pw;
        pw = eff_width(width_reg);
        send_cells(rows * pw, ocean_pct, start, restarts);
        frames_sent++;
    endtask

    // Reset width with no register write: a partial first row, too short
    // for any interior result
    task automatic test_default_width();
        send_cells(PARTIAL_CELLS, 60, 1'b1, 1'b0);
    endtask

    // Hand-built 5x5 grid: grounded tongues pointing north and south, a
    // floating pair side by side, an isolated floe beside bare ground,
    // pass-through cells carrying both thickness extremes
    task automatic test_tongue_shapes();
        t_cell grid [25];
        grid = '{CT_OCEAN, CT_OCEAN,    CT_OCEAN,    CT_OCEAN,    CT_OCEAN,
                 CT_OCEAN, CT_GROUNDED, CT_OCEAN,    CT_FLOATING, CT_GROUND,
                 CT_OCEAN, CT_GROUNDED, CT_OCEAN,    CT_GROUND,   CT_OCEAN,
                 CT_GROUND, CT_OCEAN,   CT_FLOATING, CT_FLOATING, CT_OCEAN,
                 CT_OCEAN, CT_OCEAN,    CT_OCEAN,    CT_OCEAN,    CT_OCEAN};
        set_width(CFG_W'(5));
        for (int i = 0; i < 25; i++) begin
            send_cell(grid[i], (i % 2) ? THICK_MAX : '0, i == 0);
        end
        frames_sent++;
    endtask

    // Widths below the minimum and above the buffer depth; the narrow grid
    // runs with no idling on either side
    task automatic test_width_limits();
        set_width('0);
        calm <= 1'b1;
        send_frame(CALM_ROWS, 50, 1'b1, 1'b0);
        drain();
        calm <= 1'b0;
        set_width('1);
        send_cells(PARTIAL_CELLS, 70, 1'b1, 1'b0);
    endtask

    // Mostly well-formed small grids; some run on without a frame start,
    // some restart part way through
    task automatic test_random_frames();
        int unsigned      first_cell;
        logic             fresh;
        logic [CFG_W-1:0] v;
        first_cell = cells_sent;
        fresh      = 1'b1;
        while (cells_sent - first_cell < RANDOM_CELLS) begin
            if (fresh || $urandom_range(99) < 30) begin
                if ($urandom_range(99) < 15) begin
                    v = CFG_W'($urandom_range(2));
                end else begin
                    v = CFG_W'($urandom_range(12, 3));
                end
                set_width(v);
                fresh = 1'b1;
            end
            send_frame($urandom_range(6, 3), $urandom_range(80, 30),
                       fresh || $urandom_range(99) < 85, 1'b1);
            fresh = 1'b0;
        end
    endtask

    task automatic report_bad(string what, t_centre want, t_centre got);
        failures++;
        if (failures <= REPORT_MAX) begin
            $display("%s: expected thick=%h removed=%b row_end=%b,",
                     what, want.thick, want.removed, want.row_end);
            $display("    got thick=%h removed=%b row_end=%b",
                     got.thick, got.removed, got.row_end);
        end
    endtask

    // Compare each output transfer against the oldest prediction
    always @(posedge clk) begin
        t_centre got;
        t_centre want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{thick: thick_out, removed: removed, row_end: row_end};
            results_seen++;
            if (got.removed) begin
                tips_seen++;
            end
            if (centre_q.size() == 0) begin
                report_bad("unexpected result", '0, got);
            end else begin
                want = centre_q.pop_front();
                if (got !== want) begin
                    report_bad("mismatch", want, got);
                end
            end
        end
    end

    // Random receiver stall, held off while calm
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // End the run when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCH_MAX) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     WATCH_MAX, centre_q.size());
            $display("narrow_tongue_remover_tb failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < LB_DEPTH; k++) begin
            lb_above[k] = CT_GROUND;
            lb_mid[k]   = CT_GROUND;
            lb_thick[k] = '0;
        end
        win       = '{default: CT_GROUND};
        win_thick = '{default: '0};
        col_cnt   = 0;
        row_cnt   = 0;
        width_reg = CFG_W'(PW_RESET);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_default_width();
        test_tongue_shapes();
        test_width_limits();
        test_random_frames();
        drain();

        failures += centre_q.size();
        $display("sent %0d cells in %0d grids: reset width, widths clamped low and high,",
                 cells_sent, frames_sent);
        $display("restarts and run-on grids; checked %0d interior results, %0d tips removed",
                 results_seen, tips_seen);
        if (failures == 0) begin
            $display("narrow_tongue_remover_tb passed");
        end else begin
            $display("%0d failures", failures);
            $display("narrow_tongue_remover_tb failed");
        end
        $finish;
    end

endmodule

FILE: narrow_tongue_remover.f
rtl/ntr_pkg.sv
rtl/narrow_tongue_remover.sv
rtl/ntr_checker.sv
bench/narrow_tongue_remover_tb.sv
